// ----- rtl/nbs_pkg.sv -----
// nbs_pkg: shared constants and types of the 3x3 neighbour-sum filter
// no dependencies; used by the interfaces, the cells and the top level
`default_nettype none

package nbs_pkg;

	// default frame limits for the top-level parameters
	localparam int DEF_MAX_WIDTH  = 32;
	localparam int DEF_MAX_HEIGHT = 1024;

	// register widths and reset values
	localparam int FRAME_WIDTH_BITS  = 6;
	localparam int FRAME_HEIGHT_BITS = 11;
	localparam int RESET_DIM         = 5;
	localparam int MIN_DIM           = 2;

	// configuration port
	localparam int CFG_INDEX_BITS = 2;
	localparam int CFG_DATA_BITS  = 11;
	localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_WIDTH  = 2'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_HEIGHT = 2'd1;

	localparam int SUM_BITS = 4;

	// result slots of one pixel, in delivery order
	localparam int NUM_SLOTS      = 4;
	localparam int SLOT_UP_LEFT   = 0;	// (r-1, c-1)
	localparam int SLOT_LAST_LEFT = 1;	// (r,   c-1) on the last row
	localparam int SLOT_UP_EDGE   = 2;	// (r-1, c)   on the last column
	localparam int SLOT_LAST_EDGE = 3;	// (r,   c)   last column of last row

	// one entry of the two line stores
	typedef struct packed {
		logic top;
		logic mid;
	} line_bits_t;

	// one column of the 3x3 window
	typedef struct packed {
		logic bot;
		logic mid;
		logic top;
	} col_bits_t;

endpackage

`default_nettype wire

// ----- rtl/nbs_if.sv -----
// nbs_if: valid/ready channels of the neighbour-sum filter
// pixel input, result output and configuration write; uses nbs_pkg
`default_nettype none

interface nbs_pix_if;
	logic valid;
	logic ready;
	logic pixel;

	modport source (output valid, output pixel, input ready);
	modport sink   (input valid, input pixel, output ready);
endinterface

interface nbs_res_if #(
	parameter int ROW_BITS = $clog2(nbs_pkg::DEF_MAX_HEIGHT),
	parameter int COL_BITS = $clog2(nbs_pkg::DEF_MAX_WIDTH)
);
	import nbs_pkg::*;

	logic                valid;
	logic                ready;
	logic [SUM_BITS-1:0] window_sum;
	logic [ROW_BITS-1:0] out_row;
	logic [COL_BITS-1:0] out_col;
	logic                last_in_run;
	logic                end_of_frame;

	modport source (output valid, output window_sum, output out_row, output out_col,
		output last_in_run, output end_of_frame, input ready);
	modport sink   (input valid, input window_sum, input out_row, input out_col,
		input last_in_run, input end_of_frame, output ready);
endinterface

interface nbs_cfg_if;
	import nbs_pkg::*;

	logic                      valid;
	logic                      ready;
	logic [CFG_INDEX_BITS-1:0] index;
	logic [CFG_DATA_BITS-1:0]  data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/nbs_line_cell.sv -----
// nbs_line_cell: one column entry of both line stores
// holds the pixel of the row above and of the row two above; uses nbs_pkg
`default_nettype none

module nbs_line_cell (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 wr_en,
	input  wire                 pixel,
	output nbs_pkg::line_bits_t bits
);
	import nbs_pkg::*;

	line_bits_t bits_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bits_q <= '0;
		end else if (wr_en) begin
			// row above moves up one, new pixel becomes the row above
			bits_q.top <= bits_q.mid;
			bits_q.mid <= pixel;
		end
	end

	assign bits = bits_q;

endmodule

`default_nettype wire

// ----- rtl/nbs_win_cell.sv -----
// nbs_win_cell: one column of the 3x3 window, loaded from its neighbor
// cells form a chain newest to oldest; uses nbs_pkg for the column type
`default_nettype none

module nbs_win_cell (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                shift,
	input  wire                restart,
	input  wire nbs_pkg::col_bits_t d,
	output nbs_pkg::col_bits_t q
);
	import nbs_pkg::*;

	col_bits_t col_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
		end else if (shift) begin
			col_q <= restart ? col_bits_t'('0) : d;
		end
	end

	assign q = col_q;

endmodule

`default_nettype wire

// ----- rtl/window_3x3_neighbour_sum.sv -----
// window_3x3_neighbour_sum: 3x3 box sum over a binary raster image, zero padded
// top level; uses nbs_pkg, nbs_if interfaces, nbs_line_cell and nbs_win_cell
//
// Pixels enter in raster order, one per word on pix_in, and every image position
// leaves once as a count of set pixels in its 3x3 neighbourhood on res_out, tagged
// with its row and column. A pixel releases the sum above-left of it; the last
// column of a row also releases the sum above it, and on the frame's last row each
// of these is followed by the sum of the same column in that row, so a pixel
// releases 0 to 4 sums. One sum leaves per cycle while res_out is ready, through
// a single output register that is refilled while its word is taken, so pixels
// are taken one per cycle while res_out is ready and each releases at most one
// sum; a pixel releasing more sums holds pix_in until its last sum leaves (at each
// row end, at every pixel of the last row past its first column and at the
// frame's end). The line stores are a row of MAX_WIDTH cells indexed by column,
// the window a chain of three column cells. Frame width and height are clamped to
// 2..MAX_WIDTH and 2..MAX_HEIGHT and are written through cfg, which is always ready.
`default_nettype none

module window_3x3_neighbour_sum #(
	parameter int MAX_WIDTH  = nbs_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = nbs_pkg::DEF_MAX_HEIGHT
) (
	input wire        clk,
	input wire        arst_n,
	nbs_cfg_if.sink   cfg,
	nbs_pix_if.sink   pix_in,
	nbs_res_if.source res_out
);
	import nbs_pkg::*;

	localparam int CW    = $clog2(MAX_WIDTH);
	localparam int RW    = $clog2(MAX_HEIGHT);
	localparam int WX    = FRAME_WIDTH_BITS + 1;
	localparam int HX    = (RW + 1 > FRAME_HEIGHT_BITS) ? RW + 1 : FRAME_HEIGHT_BITS;
	localparam int RST_W = (RESET_DIM > MAX_WIDTH) ? MAX_WIDTH : RESET_DIM;
	localparam int RST_H = (RESET_DIM > MAX_HEIGHT) ? MAX_HEIGHT : RESET_DIM;

	// configuration, stored already clamped
	logic [CW:0] width_q;
	logic [RW:0] height_q;
	logic [WX-1:0] w_raw;
	logic [HX-1:0] h_raw;
	logic [WX-1:0] w_clamp;
	logic [HX-1:0] h_clamp;

	assign cfg.ready = 1'b1;
	assign w_raw = WX'(cfg.data[FRAME_WIDTH_BITS-1:0]);
	assign h_raw = HX'(cfg.data[FRAME_HEIGHT_BITS-1:0]);

	always_comb begin
		if (w_raw < WX'(MIN_DIM)) begin
			w_clamp = WX'(MIN_DIM);
		end else if (w_raw > WX'(MAX_WIDTH)) begin
			w_clamp = WX'(MAX_WIDTH);
		end else begin
			w_clamp = w_raw;
		end
		if (h_raw < HX'(MIN_DIM)) begin
			h_clamp = HX'(MIN_DIM);
		end else if (h_raw > HX'(MAX_HEIGHT)) begin
			h_clamp = HX'(MAX_HEIGHT);
		end else begin
			h_clamp = h_raw;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= (CW + 1)'(RST_W);
			height_q <= (RW + 1)'(RST_H);
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				REG_FRAME_WIDTH:  width_q  <= w_clamp[CW:0];
				REG_FRAME_HEIGHT: height_q <= h_clamp[RW:0];
				default: ;
			endcase
		end
	end

	// position counters
	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic          wrap;
	logic [CW-1:0] cur_col;
	logic [RW-1:0] cur_row;
	logic [CW:0]   col_inc;
	logic [RW:0]   row_inc;
	logic          end_col;
	logic          end_row;
	logic          accept;

	assign wrap    = ({1'b0, col_q} >= width_q) || ({1'b0, row_q} >= height_q);
	assign cur_col = wrap ? '0 : col_q;
	assign cur_row = wrap ? '0 : row_q;
	assign col_inc = {1'b0, cur_col} + (CW + 1)'(1);
	assign row_inc = {1'b0, cur_row} + (RW + 1)'(1);
	assign end_col = (col_inc == width_q);
	assign end_row = (row_inc == height_q);
	assign accept  = pix_in.valid && pix_in.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (end_col) begin
				col_q <= '0;
				row_q <= end_row ? '0 : row_inc[RW-1:0];
			end else begin
				col_q <= col_inc[CW-1:0];
				row_q <= cur_row;
			end
		end
	end

	// line stores: one cell per column
	line_bits_t cell_bits [MAX_WIDTH];
	logic [MAX_WIDTH-1:0] col_sel;
	line_bits_t rd_bits;

	for (genvar i = 0; i < MAX_WIDTH; i++) begin : g_line
		assign col_sel[i] = (cur_col == CW'(i));
		nbs_line_cell u_line (
			.clk    (clk),
			.arst_n (arst_n),
			.wr_en  (accept && col_sel[i]),
			.pixel  (pix_in.pixel),
			.bits   (cell_bits[i])
		);
	end

	always_comb begin
		rd_bits = '0;
		for (int i = 0; i < MAX_WIDTH; i++) begin
			rd_bits = rd_bits | (col_sel[i] ? cell_bits[i] : line_bits_t'('0));
		end
	end

	// window: chain of column cells, index 2 newest
	col_bits_t new_col;
	col_bits_t win [3];

	assign new_col.top = rd_bits.top;
	assign new_col.mid = rd_bits.mid;
	assign new_col.bot = pix_in.pixel;

	nbs_win_cell u_win_new (
		.clk     (clk),
		.arst_n  (arst_n),
		.shift   (accept),
		.restart (1'b0),
		.d       (new_col),
		.q       (win[2])
	);

	nbs_win_cell u_win_mid (
		.clk     (clk),
		.arst_n  (arst_n),
		.shift   (accept),
		.restart (cur_col == '0),
		.d       (win[2]),
		.q       (win[1])
	);

	nbs_win_cell u_win_old (
		.clk     (clk),
		.arst_n  (arst_n),
		.shift   (accept),
		.restart (cur_col == '0),
		.d       (win[1]),
		.q       (win[0])
	);

	// pending sums of the last pixel; the window holds its data until they are gone
	logic [NUM_SLOTS-1:0] pend_q;
	logic [NUM_SLOTS-1:0] new_pend;
	logic [NUM_SLOTS-1:0] sel;
	logic [NUM_SLOTS-1:0] pend_rest;
	logic [RW-1:0]        row_s1;
	logic [CW-1:0]        col_s1;
	logic                 full_s1;
	logic                 can_load;
	logic                 emit;

	always_comb begin
		new_pend                 = '0;
		new_pend[SLOT_UP_LEFT]   = (cur_row != '0) && (cur_col != '0);
		new_pend[SLOT_LAST_LEFT] = new_pend[SLOT_UP_LEFT] && end_row;
		new_pend[SLOT_UP_EDGE]   = (cur_row != '0) && end_col;
		new_pend[SLOT_LAST_EDGE] = new_pend[SLOT_UP_EDGE] && end_row;
	end

	assign sel          = pend_q & (~pend_q + NUM_SLOTS'(1));
	assign pend_rest    = pend_q & ~sel;
	assign can_load     = !res_out.valid || res_out.ready;
	assign emit         = (pend_q != '0) && can_load;
	assign pix_in.ready = (pend_q == '0) || (emit && (pend_rest == '0));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (accept) begin
			pend_q <= new_pend;
		end else if (emit) begin
			pend_q <= pend_rest;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			row_s1  <= cur_row;
			col_s1  <= cur_col;
			full_s1 <= ({1'b0, cur_row} >= (RW + 1)'(MIN_DIM));
		end
	end

	// sum of the selected slot
	logic                all_cols;
	logic                up_row;
	logic                use_top;
	logic [SUM_BITS-1:0] sum;

	assign all_cols = sel[SLOT_UP_LEFT] || sel[SLOT_LAST_LEFT];
	assign up_row   = sel[SLOT_UP_LEFT] || sel[SLOT_UP_EDGE];
	assign use_top  = up_row && full_s1;

	always_comb begin
		sum = '0;
		for (int k = 0; k < 3; k++) begin
			if (k != 0 || all_cols) begin
				sum = sum + SUM_BITS'(win[k].top && use_top) + SUM_BITS'(win[k].mid)
					+ SUM_BITS'(win[k].bot);
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_out.valid <= 1'b0;
		end else if (emit) begin
			res_out.valid <= 1'b1;
		end else if (res_out.ready) begin
			res_out.valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			res_out.window_sum   <= sum;
			res_out.out_row      <= up_row ? row_s1 - RW'(1) : row_s1;
			res_out.out_col      <= all_cols ? col_s1 - CW'(1) : col_s1;
			res_out.last_in_run  <= (pend_rest == '0);
			res_out.end_of_frame <= sel[SLOT_LAST_EDGE];
		end
	end

endmodule

`default_nettype wire
